>>> src/chtc_pkg.sv
package chtc_pkg;

	localparam int SPEED_MAX   = 100;
	localparam int FULL_CIRCLE = 360;
	localparam int WRAP_LOW    = 300;
	localparam int WRAP_HIGH   = 350;

	localparam logic [6:0]  TURN_OFFSET_RST      = 7'd23;
	localparam logic [15:0] PWM_TOP_RST          = 16'd4095;
	localparam logic [7:0]  OVERSHOOT_MARGIN_RST = 8'd20;
	localparam logic [7:0]  HOLD_DEADBAND_RST    = 8'd10;

	typedef logic signed [7:0] speed_t;
	typedef logic signed [8:0] cmd_t;
	typedef logic [8:0]        hdg_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_TURN = 2'd1,
		PH_HOLD = 2'd2,
		PH_CORR = 2'd3
	} phase_t;

	typedef enum logic [3:0] {
		MODE_TICK         = 4'd0,
		MODE_DRIVE        = 4'd1,
		MODE_STOP         = 4'd2,
		MODE_SPEED        = 4'd3,
		MODE_LEFT_BY      = 4'd4,
		MODE_RIGHT_BY     = 4'd5,
		MODE_LEFT_TO      = 4'd6,
		MODE_RIGHT_TO     = 4'd7,
		MODE_HOLD         = 4'd8,
		MODE_STEADY_LEFT  = 4'd9,
		MODE_STEADY_RIGHT = 4'd10,
		MODE_STRAIGHT     = 4'd11
	} mode_t;

	typedef enum logic [3:0] {
		CFG_TURN_OFFSET      = 4'd0,
		CFG_PWM_TOP          = 4'd1,
		CFG_OVERSHOOT_MARGIN = 4'd2,
		CFG_HOLD_DEADBAND    = 4'd3
	} cfg_index_t;

	typedef struct packed {
		logic [6:0]  turn_offset;
		logic [15:0] pwm_top;
		logic [7:0]  overshoot_margin;
		logic [7:0]  hold_deadband;
	} cfg_t;

	typedef struct packed {
		cmd_t   left_cmd;
		cmd_t   right_cmd;
		phase_t phase;
	} status_t;

endpackage

>>> src/compass_heading_turn_controller_core.sv
// Heading controller for a two-track robot.
// Input channel (in_valid/in_ready): one beat per command or compass tick,
// carrying mode, the current heading and a signed amount.
// Output channel (out_valid/out_ready): exactly one result beat per input
// beat, in order: both track duties, reverse bits, busy flag and phase.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
// index 0 turn offset, 1 PWM top, 2 overshoot margin, 3 hold deadband.
// Other indexes are ignored. Write config only while the block is idle.
// Each beat passes the state registers, then the duty multiply stage and
// then the duty reciprocal stage before its result is valid. Throughput:
// one beat per cycle while the output is not stalled.
// A stalled output freezes the whole pipeline and drops in_ready, so no
// beat is lost; in_ready stays high while out_ready is high.
// Reset clears all heading and speed state, sets the phase to idle and
// loads the config defaults (23, 4095, 20, 10).
module compass_heading_turn_controller_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [3:0]        mode,
	input  logic [8:0]        heading,
	input  logic signed [9:0] amount,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [16:0]       left_duty,
	output logic [16:0]       right_duty,
	output logic              left_reverse,
	output logic              right_reverse,
	output logic              busy_res,
	output logic [1:0]        phase_out,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [3:0]        cfg_index,
	input  logic [15:0]       cfg_data
);
	import chtc_pkg::*;

	cfg_t    cfg_q;
	status_t status;
	logic    adv, accept;
	logic    valid_s1, valid_s2, valid_s3;
	phase_t  phase_s2, phase_s3;

	assign cfg_ready = 1'b1;
	assign adv       = !valid_s3 || out_ready;
	assign in_ready  = adv;
	assign accept    = in_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.turn_offset      <= TURN_OFFSET_RST;
			cfg_q.pwm_top          <= PWM_TOP_RST;
			cfg_q.overshoot_margin <= OVERSHOOT_MARGIN_RST;
			cfg_q.hold_deadband    <= HOLD_DEADBAND_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_TURN_OFFSET:      cfg_q.turn_offset      <= cfg_data[6:0];
				CFG_PWM_TOP:          cfg_q.pwm_top          <= cfg_data;
				CFG_OVERSHOOT_MARGIN: cfg_q.overshoot_margin <= cfg_data[7:0];
				CFG_HOLD_DEADBAND:    cfg_q.hold_deadband    <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			phase_s2 <= status.phase;
			phase_s3 <= phase_s2;
		end
	end

	chtc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.mode    (mode),
		.heading (heading),
		.amount  (amount),
		.cfg     (cfg_q),
		.status  (status)
	);

	chtc_duty u_duty_left (
		.clk     (clk),
		.en      (adv),
		.cmd     (status.left_cmd),
		.pwm_top (cfg_q.pwm_top),
		.duty    (left_duty),
		.rev     (left_reverse)
	);

	chtc_duty u_duty_right (
		.clk     (clk),
		.en      (adv),
		.cmd     (status.right_cmd),
		.pwm_top (cfg_q.pwm_top),
		.duty    (right_duty),
		.rev     (right_reverse)
	);

	assign out_valid = valid_s3;
	assign phase_out = phase_s3;
	assign busy_res  = (phase_s3 == PH_TURN) || (phase_s3 == PH_CORR);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid &&
			$stable(left_duty) && $stable(right_duty) &&
			$stable(left_reverse) && $stable(right_reverse) && $stable(phase_out))
		else $error("result beat changed while stalled");

	a_duty_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> left_duty <= {1'b0, cfg_q.pwm_top} + 17'd1 &&
			right_duty <= {1'b0, cfg_q.pwm_top} + 17'd1)
		else $error("duty above PWM period");

	a_stage_flow: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv |=> valid_s2)
		else $error("beat lost between state and multiply stage");

endmodule

>>> src/chtc_ctrl.sv
module chtc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [3:0]        mode,
	input  chtc_pkg::hdg_t    heading,
	input  logic signed [9:0] amount,
	input  chtc_pkg::cfg_t    cfg,
	output chtc_pkg::status_t status
);
	import chtc_pkg::*;

	localparam logic signed [9:0] SAT_HI = 10'(SPEED_MAX);
	localparam logic signed [9:0] SAT_LO = -SAT_HI;
	localparam logic [8:0] WRAP_LO_C = 9'(WRAP_LOW);
	localparam logic [8:0] WRAP_HI_C = 9'(WRAP_HIGH);
	localparam logic signed [10:0] CIRCLE_1 = 11'(FULL_CIRCLE);
	localparam logic signed [10:0] CIRCLE_2 = 11'(2 * FULL_CIRCLE);

	function automatic hdg_t wrap360(input logic signed [10:0] v);
		logic signed [10:0] r;
		begin
			r = v;
			if (r < 0) begin
				r = r + CIRCLE_2;
			end
			if (r >= CIRCLE_2) begin
				r = r - CIRCLE_2;
			end
			if (r >= CIRCLE_1) begin
				r = r - CIRCLE_1;
			end
			return r[8:0];
		end
	endfunction

	speed_t base_q, base_d;
	cmd_t   left_q, left_d, right_q, right_d;
	hdg_t   start_q, start_d, target_q, target_d, hold_q, hold_d;
	logic   sense_q, sense_d;
	phase_t phase_q, phase_d;

	speed_t             sat_amt;
	cmd_t               base_ext, plus_off, minus_off, left_spd, right_spd;
	logic signed [9:0]  left_tmp, right_tmp, hdiff, hneg;
	logic [8:0]         dabs;
	logic               corr_a, corr_b, above, done;
	logic signed [10:0] now_s, dst_s, t_s, hi_s, lo_s, hdg_s, amt_s;
	logic               beg_en, beg_side;
	logic signed [10:0] beg_raw;
	phase_t             beg_phase;

	always_comb begin
		if (amount > SAT_HI) begin
			sat_amt = SAT_HI[7:0];
		end else if (amount < SAT_LO) begin
			sat_amt = SAT_LO[7:0];
		end else begin
			sat_amt = amount[7:0];
		end
		base_ext  = {base_q[7], base_q};
		plus_off  = base_ext + $signed({2'b00, cfg.turn_offset});
		minus_off = base_ext - $signed({2'b00, cfg.turn_offset});
		left_tmp  = {left_q[8], left_q} - {{2{base_q[7]}}, base_q}
			+ {{2{sat_amt[7]}}, sat_amt};
		right_tmp = {right_q[8], right_q} - {{2{base_q[7]}}, base_q}
			+ {{2{sat_amt[7]}}, sat_amt};
		left_spd  = $signed(left_tmp[8:0]);
		right_spd = $signed(right_tmp[8:0]);

		hdg_s = $signed({2'b00, heading});
		amt_s = {amount[9], amount};
		t_s   = hdg_s;
		now_s = $signed({2'b00, start_q});
		dst_s = $signed({2'b00, target_q});
		hi_s  = now_s + $signed({3'b000, cfg.overshoot_margin});
		lo_s  = now_s - $signed({3'b000, cfg.overshoot_margin});
		if (!sense_q) begin
			done = (dst_s < now_s && t_s > hi_s) ||
				(t_s <= dst_s && (dst_s <= now_s || (dst_s >= now_s && t_s > hi_s)));
		end else begin
			done = (dst_s > now_s && t_s < lo_s) ||
				(t_s >= dst_s && (dst_s >= now_s || (dst_s <= now_s && t_s < lo_s)));
		end

		hdiff  = $signed({1'b0, heading}) - $signed({1'b0, hold_q});
		hneg   = -hdiff;
		dabs   = hdiff[9] ? hneg[8:0] : hdiff[8:0];
		above  = heading > hold_q;
		corr_a = dabs > {1'b0, cfg.hold_deadband} && dabs < WRAP_LO_C;
		corr_b = dabs > WRAP_LO_C && dabs < WRAP_HI_C;
	end

	always_comb begin
		base_d    = base_q;
		left_d    = left_q;
		right_d   = right_q;
		start_d   = start_q;
		target_d  = target_q;
		hold_d    = hold_q;
		sense_d   = sense_q;
		phase_d   = phase_q;
		beg_en    = 1'b0;
		beg_side  = 1'b0;
		beg_raw   = hdg_s;
		beg_phase = PH_TURN;
		unique case (mode_t'(mode))
			MODE_TICK: begin
				if (phase_q == PH_TURN || phase_q == PH_CORR) begin
					if (done) begin
						left_d  = base_ext;
						right_d = base_ext;
						phase_d = (phase_q == PH_CORR) ? PH_HOLD : PH_IDLE;
					end
				end else if (phase_q == PH_HOLD) begin
					beg_raw   = $signed({2'b00, hold_q});
					beg_phase = PH_CORR;
					if (corr_a) begin
						beg_en   = 1'b1;
						beg_side = above;
					end else if (corr_b) begin
						beg_en   = 1'b1;
						beg_side = !above;
					end
				end
			end
			MODE_DRIVE: begin
				base_d  = sat_amt;
				left_d  = {sat_amt[7], sat_amt};
				right_d = {sat_amt[7], sat_amt};
			end
			MODE_STOP: begin
				base_d  = '0;
				left_d  = '0;
				right_d = '0;
			end
			MODE_SPEED: begin
				base_d  = sat_amt;
				left_d  = left_spd;
				right_d = right_spd;
			end
			MODE_LEFT_BY: begin
				beg_en  = 1'b1;
				beg_raw = hdg_s + amt_s;
			end
			MODE_RIGHT_BY: begin
				beg_en   = 1'b1;
				beg_side = 1'b1;
				beg_raw  = hdg_s - amt_s;
			end
			MODE_LEFT_TO: begin
				beg_en  = 1'b1;
				beg_raw = amt_s;
			end
			MODE_RIGHT_TO: begin
				beg_en   = 1'b1;
				beg_side = 1'b1;
				beg_raw  = amt_s;
			end
			MODE_HOLD: begin
				phase_d = PH_HOLD;
				hold_d  = heading;
			end
			MODE_STEADY_LEFT: begin
				left_d  = minus_off;
				right_d = plus_off;
			end
			MODE_STEADY_RIGHT: begin
				left_d  = plus_off;
				right_d = minus_off;
			end
			MODE_STRAIGHT: begin
				left_d  = base_ext;
				right_d = base_ext;
			end
			default: begin
			end
		endcase
		if (beg_en) begin
			left_d   = beg_side ? plus_off : minus_off;
			right_d  = beg_side ? minus_off : plus_off;
			start_d  = heading;
			target_d = wrap360(beg_raw);
			sense_d  = !beg_side;
			phase_d  = beg_phase;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			left_q   <= '0;
			right_q  <= '0;
			start_q  <= '0;
			target_q <= '0;
			hold_q   <= '0;
			sense_q  <= 1'b0;
			phase_q  <= PH_IDLE;
		end else if (accept) begin
			base_q   <= base_d;
			left_q   <= left_d;
			right_q  <= right_d;
			start_q  <= start_d;
			target_q <= target_d;
			hold_q   <= hold_d;
			sense_q  <= sense_d;
			phase_q  <= phase_d;
		end
	end

	assign status.left_cmd  = left_q;
	assign status.right_cmd = right_q;
	assign status.phase     = phase_q;

endmodule

>>> src/chtc_duty.sv
module chtc_duty (
	input  logic          clk,
	input  logic          en,
	input  chtc_pkg::cmd_t cmd,
	input  logic [15:0]   pwm_top,
	output logic [16:0]   duty,
	output logic          rev
);
	import chtc_pkg::*;

	// floor(x / 100) == (x * RECIP100) >> 32 for every x below 2^23
	localparam logic [25:0] RECIP100 = 26'd42949673;
	localparam int          RECIP_SHIFT = 32;
	localparam logic [7:0]  FULL_MAG = 8'(SPEED_MAX);

	cmd_t        cmd_neg;
	logic [7:0]  mag;
	logic [22:0] prod;
	logic [48:0] scaled;

	logic        full_s2, rev_s2;
	logic [22:0] prod_s2;
	logic [16:0] duty_s3;
	logic        rev_s3;

	always_comb begin
		cmd_neg = -cmd;
		mag     = cmd[8] ? cmd_neg[7:0] : cmd[7:0];
		prod    = {7'b0, pwm_top} * {16'b0, mag[6:0]};
		scaled  = {26'b0, prod_s2} * {23'b0, RECIP100};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			full_s2 <= mag >= FULL_MAG;
			rev_s2  <= cmd[8];
			prod_s2 <= prod;
			duty_s3 <= full_s2 ? {1'b0, pwm_top} + 17'd1
				: scaled[RECIP_SHIFT +: 17];
			rev_s3  <= rev_s2;
		end
	end

	assign duty = duty_s3;
	assign rev  = rev_s3;

endmodule
